// File: rtl/sfdc_pkg.sv
package sfdc_pkg;

    localparam int FRAME_W = 30;
    localparam int QUEUE_W = 16;
    localparam int DRIFT_W = 8;
    localparam int STAMP_W = 31;
    localparam int GROW_W  = 31;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DRIFT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT = 2'd2;

    localparam logic [GROW_W-1:0]  GROW_INTERVAL     = 31'd30;
    localparam logic [DRIFT_W:0]   GROW_STEP         = 9'd4;
    localparam logic [DRIFT_W-1:0] RESET_MAX_DRIFT   = 8'd120;
    localparam logic [QUEUE_W-1:0] RESET_QUEUE_LIMIT = 16'd4000;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [QUEUE_W-1:0] queue_count;
        logic               is_bottleneck;
        logic               multiplayer;
    } tick_t;

    typedef struct packed {
        logic               enable;
        logic [DRIFT_W-1:0] max_drift;
        logic [QUEUE_W-1:0] queue_limit;
    } cfg_t;

    typedef struct packed {
        logic [DRIFT_W-1:0] drift_now;
        logic [STAMP_W-1:0] stamped_frame;
        logic [DRIFT_W-1:0] peak_drift_seen;
        logic [QUEUE_W-1:0] peak_queue_seen;
    } result_t;

endpackage

// File: rtl/sfdc_update.sv
module sfdc_update (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             update,
    input  sfdc_pkg::tick_t  tick,
    input  sfdc_pkg::cfg_t   cfg,
    output sfdc_pkg::result_t result
);

    logic [sfdc_pkg::DRIFT_W-1:0] drift_reg, drift_next;
    logic [sfdc_pkg::DRIFT_W-1:0] peak_drift_reg, peak_drift_next;
    logic [sfdc_pkg::QUEUE_W-1:0] peak_queue_reg, peak_queue_next;
    logic [sfdc_pkg::FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic                         last_valid_reg, last_valid_next;
    logic [sfdc_pkg::GROW_W-1:0]  next_grow_reg, next_grow_next;

    logic [sfdc_pkg::FRAME_W-1:0] elapsed;
    logic [sfdc_pkg::DRIFT_W-1:0] shrink;
    logic [sfdc_pkg::DRIFT_W:0]   grown;

    assign elapsed = tick.frame - last_frame_reg;
    assign shrink  = (elapsed < {{(sfdc_pkg::FRAME_W-sfdc_pkg::DRIFT_W){1'b0}}, drift_reg})
                     ? elapsed[sfdc_pkg::DRIFT_W-1:0] : drift_reg;
    assign grown   = {1'b0, drift_reg} + sfdc_pkg::GROW_STEP;

    always_comb
    begin
        drift_next      = drift_reg;
        peak_drift_next = peak_drift_reg;
        peak_queue_next = peak_queue_reg;
        last_frame_next = last_frame_reg;
        last_valid_next = last_valid_reg;
        next_grow_next  = next_grow_reg;
        if (!cfg.enable || !tick.multiplayer)
        begin
            drift_next = '0;
        end
        else if (!(last_valid_reg && tick.frame == last_frame_reg))
        begin
            last_frame_next = tick.frame;
            last_valid_next = 1'b1;
            if (last_valid_reg && tick.frame > last_frame_reg)
            begin
                if (tick.queue_count > peak_queue_reg)
                begin
                    peak_queue_next = tick.queue_count;
                end
                if (tick.queue_count > cfg.queue_limit || !tick.is_bottleneck)
                begin
                    drift_next = drift_reg - shrink;
                end
                else if ({1'b0, tick.frame} >= next_grow_reg)
                begin
                    next_grow_next = {1'b0, tick.frame} + sfdc_pkg::GROW_INTERVAL;
                    if (drift_reg < cfg.max_drift)
                    begin
                        drift_next = (grown > {1'b0, cfg.max_drift})
                                     ? cfg.max_drift : grown[sfdc_pkg::DRIFT_W-1:0];
                        if (drift_next > peak_drift_reg)
                        begin
                            peak_drift_next = drift_next;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg      <= '0;
            peak_drift_reg <= '0;
            peak_queue_reg <= '0;
            last_frame_reg <= '0;
            last_valid_reg <= 1'b0;
            next_grow_reg  <= '0;
        end
        else if (update)
        begin
            drift_reg      <= drift_next;
            peak_drift_reg <= peak_drift_next;
            peak_queue_reg <= peak_queue_next;
            last_frame_reg <= last_frame_next;
            last_valid_reg <= last_valid_next;
            next_grow_reg  <= next_grow_next;
        end
    end

    always_comb
    begin
        result.drift_now       = drift_next;
        result.stamped_frame   = {1'b0, tick.frame}
                                 + (cfg.enable
                                    ? {{(sfdc_pkg::STAMP_W-sfdc_pkg::DRIFT_W){1'b0}}, drift_next}
                                    : {sfdc_pkg::STAMP_W{1'b0}});
        result.peak_drift_seen = peak_drift_next;
        result.peak_queue_seen = peak_queue_next;
    end

`ifndef SYNTHESIS
    a_peak_drift_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_drift_reg >= $past(peak_drift_reg))
        else $error("peak drift decreased");

    a_peak_queue_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_queue_reg >= $past(peak_queue_reg))
        else $error("peak queue decreased");

    a_growth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (drift_reg <= $past(drift_reg)
                  || (drift_reg <= $past(cfg.max_drift)
                      && {1'b0, drift_reg} <= {1'b0, $past(drift_reg)} + sfdc_pkg::GROW_STEP)))
        else $error("drift grew past limit or step");
`endif

endmodule

// File: rtl/send_frame_drift_controller_core.sv
// send-frame drift controller
// slave stream: one transaction per game tick carrying frame and queue count in
// s_tdata and the bottleneck and multiplayer flags in s_tuser
// master stream: one result transaction per tick with drift, stamped frame and
// the two peak values packed in m_tdata
// configuration channel: cfg_index selects enable, max_drift or queue_limit,
// cfg_data carries the value; cfg_ready is always high, unknown indexes ignored
// m_tvalid rises once the tick has passed the input register and the drift
// update lands in the result register
// throughput: one tick per cycle while m_tready stays high; the drift state loop
// closes inside the update stage, so back-to-back ticks see each other's state
// reset: drift, peaks and frame history clear, enable off, max_drift 120,
// queue_limit 4000, both pipeline registers empty
// stall: while m_tready is low the result register holds, the input register
// keeps one more tick, and s_tready drops once both are full
module send_frame_drift_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sfdc_pkg::IN_TDATA_W-1:0]      s_tdata,  // frame, queue_count, zero pad
    input  logic [sfdc_pkg::IN_TUSER_W-1:0]      s_tuser,  // is_bottleneck, multiplayer
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sfdc_pkg::OUT_TDATA_W-1:0]     m_tdata,  // drift_now, stamped_frame,
                                                           // peak_drift_seen,
                                                           // peak_queue_seen, zero pad
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sfdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    sfdc_pkg::cfg_t    cfg_reg;
    sfdc_pkg::tick_t   tick_reg;
    logic              in_valid_reg;
    sfdc_pkg::result_t out_reg;
    logic              out_valid_reg;
    sfdc_pkg::result_t result;
    logic              advance;
    logic              update;

    assign advance   = !out_valid_reg || m_tready;
    assign update    = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.max_drift   <= sfdc_pkg::RESET_MAX_DRIFT;
            cfg_reg.queue_limit <= sfdc_pkg::RESET_QUEUE_LIMIT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sfdc_pkg::CFG_ENABLE:      cfg_reg.enable      <= cfg_data[0];
                sfdc_pkg::CFG_MAX_DRIFT:   cfg_reg.max_drift   <= cfg_data[sfdc_pkg::DRIFT_W-1:0];
                sfdc_pkg::CFG_QUEUE_LIMIT: cfg_reg.queue_limit <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            tick_reg.frame         <= s_tdata[sfdc_pkg::FRAME_W-1:0];
            tick_reg.queue_count   <= s_tdata[sfdc_pkg::FRAME_W +: sfdc_pkg::QUEUE_W];
            tick_reg.is_bottleneck <= s_tuser[0];
            tick_reg.multiplayer   <= s_tuser[1];
        end
        if (update)
        begin
            out_reg <= result;
        end
    end

    sfdc_update u_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (update),
        .tick   (tick_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_reg.peak_queue_seen,
                       out_reg.peak_drift_seen,
                       out_reg.stamped_frame,
                       out_reg.drift_now};

endmodule
